[hdl/rrw_pkg.sv]
package rrw_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 256;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_RESET  = 2'd2;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_RESET  = 2'd2;
   localparam logic [1:0] KIND_NOP    = 2'd3;

   localparam logic [2:0] STATUS_STORED    = 3'd0;
   localparam logic [2:0] STATUS_OUTSIDE   = 3'd1;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [2:0] STATUS_REMOVED   = 3'd3;
   localparam logic [2:0] STATUS_NOTHING   = 3'd4;
   localparam logic [2:0] STATUS_RESET     = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] seq_number;
      logic [7:0]  block_opcode;
      logic [15:0] buffer_handle;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  opcode;
      logic [15:0] handle;
   } slot_type;

   localparam int SLOT_WIDTH = $bits(slot_type);

endpackage

[hdl/rrw_ifs.sv]
interface rrw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] seq_number;
   logic [7:0]  block_opcode;
   logic [15:0] buffer_handle;

   modport source (output valid, output req_type, output seq_number,
                   output block_opcode, output buffer_handle, input ready);
   modport sink (input valid, input req_type, input seq_number,
                 input block_opcode, input buffer_handle, output ready);
endinterface

interface rrw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_opcode;
   logic [15:0] out_handle;
   logic [31:0] expected_seq;

   modport source (output valid, output status, output out_opcode,
                   output out_handle, output expected_seq, input ready);
   modport sink (input valid, input status, input out_opcode,
                 input out_handle, input expected_seq, output ready);
endinterface

[hdl/receive_reorder_window_top.sv]
// Receive reorder window over a ring of WINDOW_DEPTH slots.
// Requests arrive on the req_if channel and each one gives exactly one
// transfer on the rsp_if channel, in request order. An insert stores an
// opcode and buffer handle under its sequence number, a remove releases the
// block at the expected sequence number, and a window reset empties the ring
// and restarts the sequence at zero.
// Requests enter a two-entry queue, so the channel keeps taking requests,
// until the queue is full, while the slot engine works or waits on the
// receiver. For each request the engine reads the slot memory, then resolves
// the request and writes the slot back, and it takes the next request only
// once it is idle again. A window reset then sweeps every slot of the memory
// before the next request is started. After reset the same sweep runs;
// requests are taken into the queue meanwhile and served once it ends.
// When the receiver stalls, the finished result stays in the output register
// and the engine holds its next result until the register is free.
module receive_reorder_window_top #(
   parameter int WINDOW_DEPTH = rrw_pkg::WINDOW_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   rrw_req_if.sink   req_if,
   rrw_rsp_if.source rsp_if
);

   logic             push;
   rrw_pkg::cmd_type push_cmd;
   logic             queue_full;
   logic             pop;
   logic             q_not_empty;
   rrw_pkg::cmd_type q_cmd;

   rrw_front u_front (
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   rrw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_cmd)
   );

   rrw_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (q_cmd),
      .pop         (pop),
      .rsp_if      (rsp_if)
   );

endmodule

[hdl/rrw_ram.sv]
module rrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/rrw_front.sv]
module rrw_front (
   rrw_req_if.sink          req_if,
   input  logic             queue_full,
   output logic             push,
   output rrw_pkg::cmd_type push_cmd
);

   logic [1:0] kind;

   always_comb begin
      unique case (req_if.req_type)
         rrw_pkg::REQ_INSERT: kind = rrw_pkg::KIND_INSERT;
         rrw_pkg::REQ_REMOVE: kind = rrw_pkg::KIND_REMOVE;
         rrw_pkg::REQ_RESET:  kind = rrw_pkg::KIND_RESET;
         default:             kind = rrw_pkg::KIND_NOP;
      endcase
   end

   assign req_if.ready           = !queue_full;
   assign push                   = req_if.valid && !queue_full;
   assign push_cmd.kind          = kind;
   assign push_cmd.seq_number    = req_if.seq_number;
   assign push_cmd.block_opcode  = req_if.block_opcode;
   assign push_cmd.buffer_handle = req_if.buffer_handle;

endmodule

[hdl/rrw_queue.sv]
module rrw_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rrw_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output rrw_pkg::cmd_type head_cmd
);

   localparam int PtrW = $clog2(rrw_pkg::QUEUE_DEPTH);

   rrw_pkg::cmd_type entry_ff [rrw_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]    count_ff, count_in;

   assign full      = (count_ff == (PtrW+1)'(rrw_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(rrw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(rrw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/rrw_back.sv]
module rrw_back #(
   parameter int WINDOW_DEPTH = rrw_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  rrw_pkg::cmd_type q_cmd,
   output logic             pop,
   rrw_rsp_if.source        rsp_if
);

   localparam int IdxW = $clog2(WINDOW_DEPTH);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RESOLVE = 2'd1;
   localparam logic [1:0] ST_CLEAR   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      next_exp_ff, next_exp_in;
   logic [IdxW-1:0]  head_ff, head_in;
   logic [IdxW-1:0]  clear_cnt_ff, clear_cnt_in;
   rrw_pkg::cmd_type cmd_ff, cmd_in;
   logic [IdxW-1:0]  pos_ff, pos_in;
   logic             outside_ff, outside_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic [15:0]      handle_ff, handle_in;

   logic [31:0]       seq_dist;
   logic [IdxW:0]     pos_sum;
   logic [IdxW-1:0]   ins_pos;
   logic [IdxW-1:0]   rd_addr;
   logic              out_free;
   logic              wr_en;
   logic [IdxW-1:0]   wr_addr;
   rrw_pkg::slot_type wr_slot;
   rrw_pkg::slot_type rd_slot;
   logic [rrw_pkg::SLOT_WIDTH-1:0] rd_raw;

   assign seq_dist = q_cmd.seq_number - next_exp_ff;
   assign pos_sum  = {1'b0, head_ff} + {1'b0, seq_dist[IdxW-1:0]};
   assign ins_pos = (pos_sum >= (IdxW+1)'(WINDOW_DEPTH))
                    ? IdxW'(pos_sum - (IdxW+1)'(WINDOW_DEPTH)) : pos_sum[IdxW-1:0];
   assign rd_addr = (q_cmd.kind == rrw_pkg::KIND_INSERT) ? ins_pos : head_ff;
   assign pop      = (state_ff == ST_IDLE) && q_not_empty;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign rd_slot  = rrw_pkg::slot_type'(rd_raw);

   rrw_ram #(
      .WIDTH (rrw_pkg::SLOT_WIDTH),
      .DEPTH (WINDOW_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (pop),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   always_comb begin
      state_in     = state_ff;
      next_exp_in  = next_exp_ff;
      head_in      = head_ff;
      clear_cnt_in = clear_cnt_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      outside_in   = outside_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      status_in    = status_ff;
      opcode_in    = opcode_ff;
      handle_in    = handle_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_slot      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               cmd_in     = q_cmd;
               pos_in     = rd_addr;
               outside_in = (seq_dist > 32'(WINDOW_DEPTH - 1));
               state_in   = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               opcode_in    = '0;
               handle_in    = '0;
               status_in    = rrw_pkg::STATUS_NOTHING;
               state_in     = ST_IDLE;
               case (cmd_ff.kind)
                  rrw_pkg::KIND_INSERT: begin
                     if (outside_ff) begin
                        status_in = rrw_pkg::STATUS_OUTSIDE;
                     end else if (rd_slot.valid) begin
                        status_in = rrw_pkg::STATUS_DUPLICATE;
                     end else begin
                        wr_en          = 1'b1;
                        wr_slot.valid  = 1'b1;
                        wr_slot.opcode = cmd_ff.block_opcode;
                        wr_slot.handle = cmd_ff.buffer_handle;
                        status_in      = rrw_pkg::STATUS_STORED;
                     end
                  end
                  rrw_pkg::KIND_REMOVE: begin
                     if (rd_slot.valid) begin
                        wr_en       = 1'b1;
                        opcode_in   = rd_slot.opcode;
                        handle_in   = rd_slot.handle;
                        next_exp_in = next_exp_ff + 32'd1;
                        head_in     = (head_ff == IdxW'(WINDOW_DEPTH - 1))
                                      ? '0 : head_ff + 1'b1;
                        status_in   = rrw_pkg::STATUS_REMOVED;
                     end
                  end
                  rrw_pkg::KIND_RESET: begin
                     next_exp_in  = '0;
                     head_in      = '0;
                     clear_cnt_in = '0;
                     status_in    = rrw_pkg::STATUS_RESET;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     status_in = rrw_pkg::STATUS_NOTHING;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clear_cnt_ff;
            clear_cnt_in = clear_cnt_ff + 1'b1;
            if (clear_cnt_ff == IdxW'(WINDOW_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         next_exp_ff  <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         next_exp_ff  <= next_exp_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      outside_ff <= outside_in;
      status_ff  <= status_in;
      opcode_ff  <= opcode_in;
      handle_ff  <= handle_in;
   end

   logic [31:0] expected_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_RESOLVE && out_free) begin
         expected_ff <= next_exp_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.out_opcode   = opcode_ff;
   assign rsp_if.out_handle   = handle_ff;
   assign rsp_if.expected_seq = expected_ff;

endmodule
